// File: rtl/xgcd_pkg.sv
// xgcd_pkg: shared widths, state codes and the request/response structs for
// the extended gcd block. Used by xgcd_div and xgcd_signed_32; no dependencies.

package xgcd_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned DIV_W    = 31;
   localparam int unsigned CNT_W    = 5;
   localparam int unsigned REQ_W    = 64;
   localparam int unsigned RSP_W    = 96;

   // sequencer state codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   typedef logic [WORD_W-1:0] word_type;

   // sequencer to divider
   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
      word_type mul_a;
      word_type mul_b;
   } div_req_type;

   // divider to sequencer
   typedef struct packed {
      logic     done;
      word_type remainder;
      word_type prod_a;
      word_type prod_b;
   } div_rsp_type;

endpackage

// File: rtl/xgcd_signed_32.sv
// xgcd_signed_32: extended Euclid on signed 32-bit operands, sequencer around
// a shared serial divider/multiplier. Depends on xgcd_pkg and xgcd_div.
//
//   channel | dir | beat contents
//   req_    | in  | tdata: first_operand[31:0], second_operand[63:32]
//   rsp_    | out | tdata: divisor[30:0], first_cofactor[62:31],
//           |     |        second_cofactor[94:63], zero pad [95]
//
// a zero operand goes straight to the finish state; otherwise each Euclid
// step is one load, 32 divider bit steps and one cofactor update, so the
// run time of an item grows with its number of Euclid steps.
// reset is synchronous and returns the sequencer to idle with no result held.
// req_tready is high only while idle; a finished result waits in the output
// register, so a new item may be taken while rsp_ is stalled.

module xgcd_signed_32 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // first_operand, second_operand
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata    // divisor, first_cofactor, second_cofactor, pad
);

   logic [1:0]                state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [xgcd_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;
   xgcd_pkg::word_type        m_ff, m_in, n_ff, n_in;
   xgcd_pkg::word_type        u_ff, u_in, v_ff, v_in;
   xgcd_pkg::word_type        a_ff, a_in, b_ff, b_in;
   logic                      negm_ff, negm_in, negn_ff, negn_in;

   xgcd_pkg::div_req_type     dreq;
   xgcd_pkg::div_rsp_type     drsp;

   xgcd_pkg::word_type        raw_m, raw_n, mag_m, mag_n;
   xgcd_pkg::word_type        fin_u, fin_v;
   logic                      req_beat, out_free;

   // operand magnitudes
   always_comb begin
      raw_m = req_tdata[xgcd_pkg::WORD_W-1:0];
      raw_n = req_tdata[xgcd_pkg::REQ_W-1:xgcd_pkg::WORD_W];
      mag_m = raw_m[xgcd_pkg::WORD_W-1] ? (~raw_m + 1'b1) : raw_m;
      mag_n = raw_n[xgcd_pkg::WORD_W-1] ? (~raw_n + 1'b1) : raw_n;
   end

   assign req_tready = (state_ff == xgcd_pkg::ST_IDLE);
   assign req_beat   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // shared divider
   always_comb begin
      dreq.start    = (state_ff == xgcd_pkg::ST_LOAD);
      dreq.dividend = m_ff;
      dreq.divisor  = n_ff;
      dreq.mul_a    = a_ff;
      dreq.mul_b    = b_ff;
   end

   xgcd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   // final sign fix of the cofactors
   always_comb begin
      fin_u = negm_ff ? (~u_ff + 1'b1) : u_ff;
      fin_v = negn_ff ? (~v_ff + 1'b1) : v_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      negm_in      = negm_ff;
      negn_in      = negn_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         xgcd_pkg::ST_IDLE: begin
            if (req_beat) begin
               a_in = '0;
               b_in = xgcd_pkg::word_type'(1);
               if (mag_n == '0) begin
                  m_in     = mag_m;
                  u_in     = xgcd_pkg::word_type'(1);
                  v_in     = '0;
                  negm_in  = 1'b0;
                  negn_in  = 1'b0;
                  state_in = xgcd_pkg::ST_FIN;
               end else if (mag_m == '0) begin
                  m_in     = mag_n;
                  u_in     = '0;
                  v_in     = xgcd_pkg::word_type'(1);
                  negm_in  = 1'b0;
                  negn_in  = 1'b0;
                  state_in = xgcd_pkg::ST_FIN;
               end else begin
                  m_in     = mag_m;
                  n_in     = mag_n;
                  u_in     = xgcd_pkg::word_type'(1);
                  v_in     = '0;
                  negm_in  = raw_m[xgcd_pkg::WORD_W-1];
                  negn_in  = raw_n[xgcd_pkg::WORD_W-1];
                  state_in = xgcd_pkg::ST_LOAD;
               end
            end
         end
         xgcd_pkg::ST_LOAD: begin
            state_in = xgcd_pkg::ST_WAIT;
         end
         xgcd_pkg::ST_WAIT: begin
            // one Euclid step: shift the pairs down, q*a and q*b from the divider
            if (drsp.done) begin
               m_in     = n_ff;
               n_in     = drsp.remainder;
               u_in     = a_ff;
               a_in     = u_ff - drsp.prod_a;
               v_in     = b_ff;
               b_in     = v_ff - drsp.prod_b;
               state_in = (drsp.remainder == '0) ? xgcd_pkg::ST_FIN : xgcd_pkg::ST_LOAD;
            end
         end
         xgcd_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, fin_v, fin_u, m_ff[xgcd_pkg::DIV_W-1:0]};
               state_in     = xgcd_pkg::ST_IDLE;
            end
         end
         default: state_in = xgcd_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xgcd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      n_ff        <= n_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      negm_ff     <= negm_in;
      negn_ff     <= negn_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/xgcd_div.sv
// xgcd_div: serial restoring divider, one quotient bit per cycle, that also
// builds q*a and q*b (mod 2^32) by shift-and-add as quotient bits appear.
// Depends on xgcd_pkg.

module xgcd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  xgcd_pkg::div_req_type req,
   output xgcd_pkg::div_rsp_type rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [xgcd_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   xgcd_pkg::word_type            rem_ff, rem_in;
   xgcd_pkg::word_type            dvd_ff, dvd_in;
   xgcd_pkg::word_type            pa_ff, pa_in;
   xgcd_pkg::word_type            pb_ff, pb_in;

   logic [xgcd_pkg::WORD_W:0]     shifted;
   logic [xgcd_pkg::WORD_W:0]     diff;
   logic                          qbit;

   // one restoring step: shift in next dividend bit, trial subtract
   always_comb begin
      shifted = {rem_ff, dvd_ff[xgcd_pkg::WORD_W-1]};
      diff    = shifted - {1'b0, req.divisor};
      qbit    = ~diff[xgcd_pkg::WORD_W];
   end

   // next-state for the iteration
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      pa_in   = pa_ff;
      pb_in   = pb_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = req.dividend;
         pa_in   = '0;
         pb_in   = '0;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[xgcd_pkg::WORD_W-1:0] : shifted[xgcd_pkg::WORD_W-1:0];
         dvd_in = {dvd_ff[xgcd_pkg::WORD_W-2:0], 1'b0};
         pa_in  = {pa_ff[xgcd_pkg::WORD_W-2:0], 1'b0} + (qbit ? req.mul_a : '0);
         pb_in  = {pb_ff[xgcd_pkg::WORD_W-2:0], 1'b0} + (qbit ? req.mul_b : '0);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == {xgcd_pkg::CNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
   end

   always_comb begin
      rsp.done      = done_ff;
      rsp.remainder = rem_ff;
      rsp.prod_a    = pa_ff;
      rsp.prod_b    = pb_ff;
   end

endmodule

// File: rtl/xgcd_check.sv
// xgcd_check: port-level checks for xgcd_signed_32, attached by bind.
// Depends only on the top level's ports.

module xgcd_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // pad bit of a result beat is zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[95] == 1'b0)
      else $error("rsp pad bit set");

   // block is busy right after taking an item
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while busy");

   // zero second operand gives cofactors 1 and 0 on the result beat
   a_zero_n: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[63:32] == 32'd0 &&
      (!rsp_tvalid || rsp_tready)
      |=> ##1 rsp_tvalid && rsp_tdata[62:31] == 32'd1 && rsp_tdata[94:63] == 32'd0)
      else $error("zero second operand result wrong");

endmodule

bind xgcd_signed_32 xgcd_check u_xgcd_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
